// ===== src/pwce_pkg.sv =====
// shared types, codes and phase functions for the single-wire command engine
// no dependencies; used by the interfaces, pwce_seq and the top level
`timescale 1ns / 1ps
`default_nettype none

package pwce_pkg;

    // request operation codes
    localparam logic [2:0] OP_TICK       = 3'd0;
    localparam logic [2:0] OP_ENTER      = 3'd1;
    localparam logic [2:0] OP_WRITE      = 3'd2;
    localparam logic [2:0] OP_READ       = 3'd3;
    localparam logic [2:0] OP_POWER_DOWN = 3'd4;

    localparam logic [23:0] UNLOCK_WORD = 24'h9416F4;

    localparam logic [4:0] SEND_BITS_LONG  = 5'd24;
    localparam logic [4:0] SEND_BITS_SHORT = 5'd8;
    localparam logic [4:0] RECV_BITS       = 5'd16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_TIME     = 3'd0,
        CFG_STOP_TIME      = 3'd1,
        CFG_BIT_TIME       = 3'd2,
        CFG_ZERO_HIGH_TIME = 3'd3,
        CFG_ONE_HIGH_TIME  = 3'd4,
        CFG_TAKEOVER_TIME  = 3'd5,
        CFG_POWER_ON_TIME  = 3'd6,
        CFG_SETTLE_TIME    = 3'd7
    } t_cfg_idx;

    localparam logic [9:0]  RST_START_TIME     = 10'd10;
    localparam logic [9:0]  RST_STOP_TIME      = 10'd10;
    localparam logic [9:0]  RST_BIT_TIME       = 10'd60;
    localparam logic [9:0]  RST_ZERO_HIGH_TIME = 10'd15;
    localparam logic [9:0]  RST_ONE_HIGH_TIME  = 10'd45;
    localparam logic [9:0]  RST_TAKEOVER_TIME  = 10'd25;
    localparam logic [19:0] RST_POWER_ON_TIME  = 20'd1000;
    localparam logic [19:0] RST_SETTLE_TIME    = 20'd500000;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_POWER  = 4'd1,
        PH_ST1    = 4'd2,
        PH_BH     = 4'd3,
        PH_BL     = 4'd4,
        PH_STOP   = 4'd5,
        PH_SETTLE = 4'd6,
        PH_HO1    = 4'd7,
        PH_HO2    = 4'd8,
        PH_HO3    = 4'd9,
        PH_RXA    = 4'd10,
        PH_RXS    = 4'd11,
        PH_RXB    = 4'd12,
        PH_TKW    = 4'd13,
        PH_TKL    = 4'd14,
        PH_ST2    = 4'd15
    } t_phase;

    typedef enum logic [1:0] {
        SEQ_ENTER = 2'd0,
        SEQ_WRITE = 2'd1,
        SEQ_READ  = 2'd2
    } t_seq_kind;

    typedef struct packed {
        logic [9:0]  start_time;
        logic [9:0]  stop_time;
        logic [9:0]  bit_time;
        logic [9:0]  zero_high_time;
        logic [9:0]  one_high_time;
        logic [9:0]  takeover_time;
        logic [19:0] power_on_time;
        logic [19:0] settle_time;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  command;
        logic [15:0] value;
        logic        line_in;
    } t_item;

    typedef struct packed {
        logic        line_out;
        logic        line_drive;
        logic        supply_on;
        logic        busy_res;
        logic        refused;
        logic        read_done;
        logic [15:0] read_word;
    } t_result;

    // line levels and flags held for a request still being worked on
    typedef struct packed {
        logic line_out;
        logic line_drive;
        logic supply_on;
        logic busy_res;
        logic refused;
    } t_cap;

    typedef struct packed {
        t_phase      phase;
        logic [19:0] tick_timer;
        logic [4:0]  bit_counter;
        logic [23:0] send_shift;
        logic [15:0] receive_shift;
        logic        line_level;
        logic        line_enable;
        logic        supply_level;
        t_seq_kind   seq_kind;
        logic [15:0] last_word;
    } t_seq_state;

    typedef struct packed {
        t_seq_state s;
        t_phase     ph;
        logic       done;
    } t_step;

    typedef struct packed {
        t_seq_state s;
        logic       fin;
        t_phase     ph;
        logic       done;
    } t_enter;

    function automatic logic [19:0] phase_len(t_phase ph, logic send_msb, t_cfg c);
        logic [9:0]  high;
        logic [8:0]  half;
        logic [19:0] len;
        high = send_msb ? c.one_high_time : c.zero_high_time;
        half = c.bit_time[9:1];
        case (ph)
            PH_POWER:         len = c.power_on_time;
            PH_ST1, PH_ST2:   len = {10'd0, c.start_time};
            PH_BH:            len = {10'd0, high};
            PH_BL:            len = (c.bit_time > high) ? {10'd0, c.bit_time - high} : 20'd0;
            PH_STOP:          len = {10'd0, c.stop_time};
            PH_SETTLE:        len = c.settle_time;
            PH_HO1, PH_HO3:   len = {10'd0, c.zero_high_time};
            PH_HO2:           len = {9'd0, c.zero_high_time, 1'b0};
            PH_RXA:           len = {11'd0, half};
            PH_RXS:           len = 20'd1;
            PH_RXB:           len = (half != 9'd0) ? {11'd0, half - 9'd1} : 20'd0;
            PH_TKW:           len = {10'd0, c.one_high_time};
            PH_TKL:           len = {10'd0, c.takeover_time};
            default:          len = 20'd0;
        endcase
        return len;
    endfunction

    function automatic t_seq_state apply_levels(t_seq_state s, t_phase ph);
        t_seq_state r;
        r = s;
        case (ph)
            PH_POWER: begin
                r.supply_level = 1'b1;
                r.line_enable  = 1'b1;
                r.line_level   = 1'b1;
            end
            PH_BH, PH_STOP, PH_HO1: begin
                r.line_enable = 1'b1;
                r.line_level  = 1'b1;
            end
            PH_ST1, PH_ST2, PH_BL, PH_HO2, PH_TKL: begin
                r.line_enable = 1'b1;
                r.line_level  = 1'b0;
            end
            PH_HO3, PH_RXA, PH_RXS, PH_RXB, PH_TKW: begin
                r.line_enable = 1'b0;
                r.line_level  = 1'b0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // phase that follows ph, with the shift and counter updates of leaving it
    function automatic t_step next_phase(t_seq_state s, t_phase ph);
        t_step r;
        r.s    = s;
        r.ph   = PH_IDLE;
        r.done = 1'b0;
        case (ph)
            PH_POWER: r.ph = PH_ST1;
            PH_ST1:   r.ph = PH_BH;
            PH_BH:    r.ph = PH_BL;
            PH_BL: begin
                r.s.send_shift  = {s.send_shift[22:0], 1'b0};
                r.s.bit_counter = s.bit_counter - 5'd1;
                if (r.s.bit_counter != 5'd0) begin
                    r.ph = PH_BH;
                end else if (s.seq_kind == SEQ_ENTER) begin
                    r.ph = PH_STOP;
                end else if (s.seq_kind == SEQ_WRITE) begin
                    r.ph = PH_ST2;
                end else begin
                    r.s.bit_counter   = RECV_BITS;
                    r.s.receive_shift = 16'd0;
                    r.ph              = PH_HO1;
                end
            end
            PH_STOP: r.ph = PH_SETTLE;
            PH_HO1:  r.ph = PH_HO2;
            PH_HO2:  r.ph = PH_HO3;
            PH_HO3:  r.ph = PH_RXA;
            PH_RXA:  r.ph = PH_RXS;
            PH_RXS:  r.ph = PH_RXB;
            PH_RXB: begin
                r.s.bit_counter = s.bit_counter - 5'd1;
                r.ph = (r.s.bit_counter != 5'd0) ? PH_RXA : PH_TKW;
            end
            PH_TKW: r.ph = PH_TKL;
            PH_TKL: r.ph = PH_ST2;
            PH_ST2: begin
                if (s.seq_kind == SEQ_READ) begin
                    r.s.last_word = s.receive_shift;
                    r.done        = 1'b1;
                    r.ph          = PH_IDLE;
                end else begin
                    r.ph = PH_SETTLE;
                end
            end
            default: r.ph = PH_IDLE;
        endcase
        return r;
    endfunction

    // one phase entry: loads the timer, or leaves the phase at once when its length is zero
    function automatic t_enter enter_step(t_seq_state s, t_phase ph, t_cfg c);
        t_enter      r;
        t_step       st;
        logic [19:0] len;
        r.s       = s;
        r.s.phase = ph;
        r.fin     = 1'b1;
        r.ph      = PH_IDLE;
        r.done    = 1'b0;
        len       = phase_len(ph, s.send_shift[23], c);
        if (ph == PH_IDLE) begin
            r.s.tick_timer = 20'd0;
        end else begin
            r.s = apply_levels(r.s, ph);
            if (len != 20'd0) begin
                r.s.tick_timer = len;
            end else begin
                st     = next_phase(r.s, ph);
                r.s    = st.s;
                r.ph   = st.ph;
                r.done = st.done;
                r.fin  = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/pwce_if.sv =====
// request and result channel interfaces of the single-wire command engine
// depends on pwce_pkg
`timescale 1ns / 1ps
`default_nettype none

interface pwce_in_if;
    import pwce_pkg::*;

    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [7:0]  command;
    logic [15:0] value;
    logic        line_in;

    modport source (output valid, op, command, value, line_in, input ready);
    modport sink (input valid, op, command, value, line_in, output ready);
endinterface

interface pwce_out_if;
    import pwce_pkg::*;

    logic        valid;
    logic        ready;
    logic        line_out;
    logic        line_drive;
    logic        supply_on;
    logic        busy_res;
    logic        refused;
    logic        read_done;
    logic [15:0] read_word;

    modport source (output valid, line_out, line_drive, supply_on, busy_res, refused,
                    read_done, read_word, input ready);
    modport sink (input valid, line_out, line_drive, supply_on, busy_res, refused,
                  read_done, read_word, output ready);
endinterface

`default_nettype wire

// ===== src/pulse_width_one_wire_command_engine_top.sv =====
// top level of the single-wire command engine: configuration registers,
// request/result handshake and result register; depends on pwce_pkg, pwce_if, pwce_seq
`timescale 1ns / 1ps
`default_nettype none

// Master for a single-wire sensor programming link. Every request on i_in is one
// timing tick (one microsecond of link time); a request with op enter, write, read or
// power down that arrives while the engine is idle starts that sequence, and the same
// request already counts as its first tick. Each request gives exactly one result on
// o_out with the line level, drive enable, supply switch, busy, refused and read status
// for that tick. Throughput is one request per clock cycle while the result slot is free
// or being emptied: the whole tick is worked out between the phase/timer registers and
// the result register. Where a phase has a length of zero (for example a takeover time
// of zero, or a high time not below the bit time) the tick runs straight through it;
// the phase-entry logic handles up to two phase entries per cycle, and i_in.ready is
// low while further ones are entered. Configuration registers are written through
// i_cfg_we / i_cfg_index / i_cfg_data and must only be changed while the engine is idle.
module pulse_width_one_wire_command_engine_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [pwce_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [pwce_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    pwce_in_if.sink                               i_in,
    pwce_out_if.source                            o_out
);
    import pwce_pkg::*;

    t_cfg    r_cfg;
    logic    r_out_valid;
    t_result r_out;

    logic    w_in_ready;
    logic    w_accept;
    logic    w_pend;
    logic    w_res_valid;
    t_item   w_item;
    t_result w_res;

    // configuration registers, written by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_time     <= RST_START_TIME;
            r_cfg.stop_time      <= RST_STOP_TIME;
            r_cfg.bit_time       <= RST_BIT_TIME;
            r_cfg.zero_high_time <= RST_ZERO_HIGH_TIME;
            r_cfg.one_high_time  <= RST_ONE_HIGH_TIME;
            r_cfg.takeover_time  <= RST_TAKEOVER_TIME;
            r_cfg.power_on_time  <= RST_POWER_ON_TIME;
            r_cfg.settle_time    <= RST_SETTLE_TIME;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_START_TIME:     r_cfg.start_time     <= i_cfg_data[9:0];
                CFG_STOP_TIME:      r_cfg.stop_time      <= i_cfg_data[9:0];
                CFG_BIT_TIME:       r_cfg.bit_time       <= i_cfg_data[9:0];
                CFG_ZERO_HIGH_TIME: r_cfg.zero_high_time <= i_cfg_data[9:0];
                CFG_ONE_HIGH_TIME:  r_cfg.one_high_time  <= i_cfg_data[9:0];
                CFG_TAKEOVER_TIME:  r_cfg.takeover_time  <= i_cfg_data[9:0];
                CFG_POWER_ON_TIME:  r_cfg.power_on_time  <= i_cfg_data;
                CFG_SETTLE_TIME:    r_cfg.settle_time    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // a new request goes in when no tick is still being resolved and the result slot
    // is free or being emptied in the same cycle
    assign w_in_ready = !w_pend && (!r_out_valid || o_out.ready);
    assign w_accept   = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;

    assign w_item.op      = i_in.op;
    assign w_item.command = i_in.command;
    assign w_item.value   = i_in.value;
    assign w_item.line_in = i_in.line_in;

    pwce_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (w_accept),
        .i_item      (w_item),
        .o_pend      (w_pend),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // result register; only one request is in flight, so a new result never meets a
    // full slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.line_out   = r_out.line_out;
    assign o_out.line_drive = r_out.line_drive;
    assign o_out.supply_on  = r_out.supply_on;
    assign o_out.busy_res   = r_out.busy_res;
    assign o_out.refused    = r_out.refused;
    assign o_out.read_done  = r_out.read_done;
    assign o_out.read_word  = r_out.read_word;

endmodule

`default_nettype wire

// ===== src/pwce_seq.sv =====
// phase sequencer: timer, bit shifters and line levels, one tick per request
// depends on pwce_pkg
`timescale 1ns / 1ps
`default_nettype none

module pwce_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pwce_pkg::t_cfg    i_cfg,
    input  wire logic              i_accept,
    input  wire pwce_pkg::t_item   i_item,
    output logic                   o_pend,
    output logic                   o_res_valid,
    output pwce_pkg::t_result      o_res
);
    import pwce_pkg::*;

    t_seq_state r_state, n_state;
    logic       r_pend, n_pend;
    t_phase     r_target, n_target;
    logic       r_tick_pend, n_tick_pend;
    logic       r_done_acc, n_done_acc;
    t_cap       r_cap, n_cap;
    logic       r_lin, n_lin;

    t_seq_state base, s1, s2;
    t_enter     e1, e2;
    t_step      np;
    t_phase     target;
    t_cap       cap_now;
    logic       do_enter, tick_pend, lin, fin1, expire, done_acc, refused, done_all;

    always_comb begin
        base      = r_state;
        do_enter  = r_pend;
        target    = r_target;
        tick_pend = r_tick_pend;
        lin       = r_lin;
        done_acc  = r_done_acc;
        refused   = r_cap.refused;

        // a fresh request: start a sequence or power down, or flag it as refused
        if (!r_pend) begin
            done_acc  = 1'b0;
            tick_pend = 1'b1;
            lin       = i_item.line_in;
            refused   = 1'b0;
            target    = PH_ST1;
            if (r_state.phase == PH_IDLE) begin
                case (i_item.op)
                    OP_ENTER: begin
                        base.seq_kind    = SEQ_ENTER;
                        base.send_shift  = UNLOCK_WORD;
                        base.bit_counter = SEND_BITS_LONG;
                        do_enter         = 1'b1;
                        target           = PH_POWER;
                    end
                    OP_WRITE: begin
                        base.seq_kind    = SEQ_WRITE;
                        base.send_shift  = {i_item.command, i_item.value};
                        base.bit_counter = SEND_BITS_LONG;
                        do_enter         = 1'b1;
                    end
                    OP_READ: begin
                        base.seq_kind    = SEQ_READ;
                        base.send_shift  = {i_item.command, 16'd0};
                        base.bit_counter = SEND_BITS_SHORT;
                        do_enter         = 1'b1;
                    end
                    OP_POWER_DOWN: begin
                        base.supply_level = 1'b0;
                        base.line_enable  = 1'b1;
                        base.line_level   = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end else begin
                refused = i_item.op inside {OP_ENTER, OP_WRITE, OP_READ, OP_POWER_DOWN};
            end
        end

        e1   = enter_step(base, target, i_cfg);
        s1   = do_enter ? e1.s : base;
        fin1 = !do_enter || e1.fin;
        if (do_enter) begin
            done_acc = done_acc | e1.done;
        end

        cap_now.line_out   = s1.line_enable & s1.line_level;
        cap_now.line_drive = s1.line_enable;
        cap_now.supply_on  = s1.supply_level;
        cap_now.busy_res   = (s1.phase != PH_IDLE);
        cap_now.refused    = refused;

        // the tick itself: sample, count down, move on when the phase runs out
        s2 = s1;
        if (s1.phase != PH_IDLE) begin
            if (s1.phase == PH_RXS) begin
                s2.receive_shift = {s1.receive_shift[14:0], lin};
            end
            s2.tick_timer = s1.tick_timer - 20'd1;
        end
        expire   = (s1.phase != PH_IDLE) && (s2.tick_timer == 20'd0);
        np       = next_phase(s2, s2.phase);
        e2       = enter_step(np.s, np.ph, i_cfg);
        done_all = done_acc | np.done | e2.done;
    end

    always_comb begin
        n_state     = r_state;
        n_pend      = r_pend;
        n_target    = r_target;
        n_tick_pend = r_tick_pend;
        n_done_acc  = r_done_acc;
        n_cap       = r_cap;
        n_lin       = r_lin;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (r_pend || i_accept) begin
            n_lin = lin;
            if (!fin1) begin
                n_state       = s1;
                n_pend        = 1'b1;
                n_target      = e1.ph;
                n_tick_pend   = tick_pend;
                n_done_acc    = done_acc;
                n_cap.refused = refused;
            end else if (tick_pend && expire && !e2.fin) begin
                n_state     = e2.s;
                n_pend      = 1'b1;
                n_target    = e2.ph;
                n_tick_pend = 1'b0;
                n_done_acc  = done_all;
                n_cap       = cap_now;
            end else begin
                n_pend      = 1'b0;
                o_res_valid = 1'b1;
                if (tick_pend) begin
                    n_state           = expire ? e2.s : s2;
                    o_res.line_out    = cap_now.line_out;
                    o_res.line_drive  = cap_now.line_drive;
                    o_res.supply_on   = cap_now.supply_on;
                    o_res.busy_res    = cap_now.busy_res;
                    o_res.refused     = cap_now.refused;
                    o_res.read_done   = expire ? done_all : done_acc;
                    o_res.read_word   = expire ? e2.s.last_word : s2.last_word;
                end else begin
                    n_state           = s1;
                    o_res.line_out    = r_cap.line_out;
                    o_res.line_drive  = r_cap.line_drive;
                    o_res.supply_on   = r_cap.supply_on;
                    o_res.busy_res    = r_cap.busy_res;
                    o_res.refused     = r_cap.refused;
                    o_res.read_done   = done_acc;
                    o_res.read_word   = s1.last_word;
                end
            end
        end
    end

    assign o_pend = r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_pend      <= 1'b0;
            r_target    <= PH_IDLE;
            r_tick_pend <= 1'b0;
            r_done_acc  <= 1'b0;
            r_cap       <= '0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_target    <= n_target;
            r_tick_pend <= n_tick_pend;
            r_done_acc  <= n_done_acc;
            r_cap       <= n_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lin <= n_lin;
    end

endmodule

`default_nettype wire
